### rtl/pecb_pkg.sv
// ----------------------------------------------------------------------------
// pecb_pkg
// Shared types and constants for the endpoint config space and BAR windows.
// ----------------------------------------------------------------------------
package pecb_pkg;

    typedef enum logic [1:0] {
        ACT_CFG_RD = 2'd0,
        ACT_CFG_WR = 2'd1,
        ACT_MEM_RD = 2'd2,
        ACT_MEM_WR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISALIGN = 2'd1,
        ST_RANGE    = 2'd2,
        ST_BAR_BAD  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_DONE   = 2'd0,
        OP_CFG_RD = 2'd1,
        OP_CFG_WR = 2'd2,
        OP_MEM    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        BS_RUN   = 2'd0,
        BS_READ  = 2'd1,
        BS_CLEAR = 2'd2
    } t_back_state;

    localparam logic [0:0] REG_VENDOR = 1'b0;
    localparam logic [0:0] REG_DEVICE = 1'b1;
    localparam int unsigned BAR_COUNT = 6;
    localparam logic [11:0] BAR_BASE = 12'h010;
    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [31:0] BAR_TYPE = 32'h1;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  bar_select;
        logic [11:0] address;
        logic [31:0] write_data;
        logic [2:0]  access_length;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  bytes_done;
        logic [1:0]  status;
    } t_out_beat;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        t_op         op;
        t_status     status;
        logic        is_write;
        logic        sel_ram;
        logic [2:0]  bar_idx;
        logic [16:0] offset;
        logic [2:0]  count;
        logic [31:0] write_data;
    } t_cmd;

endpackage

### rtl/pecb_front.sv
// ----------------------------------------------------------------------------
// pecb_front
// Classifies input beats: alignment, BAR decode, range check and length truncation.
// ----------------------------------------------------------------------------
module pecb_front
    import pecb_pkg::*;
#(
    parameter int unsigned ROM_BYTES = 128,
    parameter int unsigned RAM_BYTES = 2048
) (
    input  t_in_beat          i_beat,
    input  logic [BAR_COUNT-1:0] i_bar_en,
    output t_cmd              o_cmd
);

    localparam logic [16:0] ROM_SZ = 17'(ROM_BYTES);
    localparam logic [16:0] RAM_SZ = 17'(RAM_BYTES);

    logic [16:0] sz;
    logic [16:0] addr;
    logic [16:0] room;
    logic [2:0]  len;
    logic [11:0] rel;

    always_comb begin
        o_cmd = '0;
        o_cmd.op = OP_DONE;
        o_cmd.status = ST_OK;
        o_cmd.write_data = i_beat.write_data;
        addr = {5'd0, i_beat.address};
        sz = (i_beat.bar_select == 3'd0) ? ROM_SZ : RAM_SZ;
        room = sz - addr;
        len = (i_beat.access_length > 3'd4) ? 3'd4 : i_beat.access_length;
        rel = i_beat.address - BAR_BASE;
        if (i_beat.action == ACT_CFG_RD || i_beat.action == ACT_CFG_WR) begin
            if (i_beat.address[1:0] != 2'd0 || i_beat.access_length != 3'd4) begin
                o_cmd.status = ST_MISALIGN;
            end else begin
                o_cmd.count = 3'd4;
                o_cmd.bar_idx = rel[4:2];
                o_cmd.offset = addr;
                o_cmd.op = (i_beat.action == ACT_CFG_RD) ? OP_CFG_RD : OP_CFG_WR;
            end
        end else begin
            o_cmd.is_write = (i_beat.action == ACT_MEM_WR);
            o_cmd.sel_ram = (i_beat.bar_select == 3'd1);
            if (i_beat.bar_select >= 3'd2 || !i_bar_en[i_beat.bar_select[2:0]]
                || (o_cmd.is_write && i_beat.bar_select == 3'd0)) begin
                o_cmd.status = ST_BAR_BAD;
            end else if (addr > sz) begin
                o_cmd.status = ST_RANGE;
            end else begin
                o_cmd.op = OP_MEM;
                o_cmd.offset = addr;
                o_cmd.count = ({14'd0, len} > room) ? room[2:0] : len;
            end
        end
    end

endmodule

### rtl/pecb_queue.sv
// ----------------------------------------------------------------------------
// pecb_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pecb_queue
    import pecb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd = r_mem[r_rp];

endmodule

### rtl/pecb_back.sv
// ----------------------------------------------------------------------------
// pecb_back
// Executes commands: BAR registers, ROM and RAM windows, result register.
// ----------------------------------------------------------------------------
module pecb_back
    import pecb_pkg::*;
#(
    parameter int unsigned ROM_BYTES = 128,
    parameter int unsigned RAM_BYTES = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_vendor,
    input  logic [15:0]       i_device,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic [BAR_COUNT-1:0] o_bar_en,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_beat         o_beat
);

    localparam int unsigned RAW = $clog2(RAM_BYTES);
    localparam logic [31:0] RAM_MASK = ~(32'(RAM_BYTES) - 32'd1);
    localparam logic [31:0] ROM_MASK = ~(32'(ROM_BYTES) - 32'd1);

    t_back_state r_state, n_state;
    logic [31:0] r_bar [BAR_COUNT];
    logic [BAR_COUNT-1:0] r_en;
    logic [7:0]  r_ram [RAM_BYTES];
    logic [7:0]  r_rdb;
    logic [RAW:0] r_clr;
    logic [2:0]  r_i, n_i;
    logic [31:0] r_acc, n_acc;
    logic        r_ov, n_ov;
    t_out_beat   r_out, n_out;
    logic        pop, ram_we, rd_en, out_free;
    logic [RAW-1:0] ram_wa, rd_a;
    logic [7:0]  ram_wd;
    logic [16:0] a;
    logic [7:0]  romv;
    logic [2:0]  bi;
    logic        in_bars;

    assign out_free = !r_ov || !i_stall;
    assign o_valid = r_ov;
    assign o_beat = r_out;
    assign o_bar_en = r_en;
    assign o_cmd_pop = pop;
    assign bi = i_cmd.bar_idx;
    assign in_bars = i_cmd.offset >= 17'(BAR_BASE) && i_cmd.offset < 17'(BAR_BASE + 12'd24);
    assign a = i_cmd.offset + 17'(r_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_CLEAR;
            r_clr <= '0;
            r_i <= '0;
            r_acc <= '0;
            r_ov <= 1'b0;
            r_en <= '0;
            for (int k = 0; k < BAR_COUNT; k++) r_bar[k] <= (k < 2) ? BAR_TYPE : 32'd0;
        end else begin
            r_state <= n_state;
            r_i <= n_i;
            r_acc <= n_acc;
            r_ov <= n_ov;
            if (r_state == BS_CLEAR) r_clr <= r_clr + 1'b1;
            if (pop && i_cmd.op == OP_CFG_WR && in_bars) begin
                r_bar[bi] <= (bi == 3'd0) ? ((i_cmd.write_data & ROM_MASK) | BAR_TYPE)
                           : (bi == 3'd1) ? ((i_cmd.write_data & RAM_MASK) | BAR_TYPE)
                           : 32'd0;
                if (i_cmd.write_data != ALL_ONES) r_en[bi] <= 1'b1;
            end
        end
        r_out <= n_out;
        if (ram_we) r_ram[ram_wa] <= ram_wd;
        if (rd_en) r_rdb <= r_ram[rd_a];
    end

    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_acc = r_acc;
        n_ov = r_ov && i_stall;
        n_out = r_out;
        pop = 1'b0;
        ram_we = 1'b0;
        ram_wa = a[RAW-1:0];
        ram_wd = i_cmd.write_data[8*r_i[1:0] +: 8];
        rd_en = 1'b0;
        rd_a = a[RAW-1:0];
        romv = a[7:0] + 8'h10;
        case (r_state)
            BS_CLEAR: begin
                ram_we = 1'b1;
                ram_wa = r_clr[RAW-1:0];
                ram_wd = 8'd0;
                if (r_clr == (RAW+1)'(RAM_BYTES - 1)) n_state = BS_RUN;
            end
            BS_RUN: begin
                if (i_cmd_valid && out_free) begin
                    if (i_cmd.op == OP_MEM && r_i != i_cmd.count) begin
                        if (i_cmd.is_write) begin
                            ram_we = 1'b1;
                            n_i = r_i + 3'd1;
                        end else if (i_cmd.sel_ram) begin
                            rd_en = 1'b1;
                            n_state = BS_READ;
                        end else begin
                            n_acc = r_acc | (32'(romv) << (8 * r_i[1:0]));
                            n_i = r_i + 3'd1;
                        end
                    end else begin
                        pop = 1'b1;
                        n_ov = 1'b1;
                        n_i = '0;
                        n_acc = '0;
                        n_out.status = i_cmd.status;
                        n_out.bytes_done = i_cmd.count;
                        n_out.read_data = '0;
                        if (i_cmd.op == OP_MEM && !i_cmd.is_write) n_out.read_data = r_acc;
                        if (i_cmd.op == OP_CFG_RD) begin
                            if (i_cmd.offset == 17'd0) n_out.read_data = {i_device, i_vendor};
                            else if (in_bars) n_out.read_data = r_bar[bi];
                        end
                    end
                end
            end
            BS_READ: begin
                n_acc = r_acc | (32'(r_rdb) << (8 * r_i[1:0]));
                n_i = r_i + 3'd1;
                n_state = BS_RUN;
            end
            default: n_state = BS_RUN;
        endcase
    end

endmodule

### rtl/pcie_endpoint_config_and_bar_memory.sv
// ----------------------------------------------------------------------------
// pcie_endpoint_config_and_bar_memory
// Type-0 endpoint config header with a read-only BAR0 and a writable BAR1.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// in        input      i_valid / o_stall
// out       output     o_valid / i_stall
// cfg       input      i_cfg_we, no handshake
// A config beat is decoded and queued, then executed by the back end.
// A ROM read or RAM write handles one byte per step, and a RAM read fetches
// each byte through the registered RAM port.
// Input stalls while the queue holds a command; a stalled result holds the back end.
// After reset the back end clears the RAM byte by byte; one beat may be accepted
// meanwhile and waits in the queue.
module pcie_endpoint_config_and_bar_memory
    import pecb_pkg::*;
#(
    parameter int unsigned ROM_BYTES = 128,
    parameter int unsigned RAM_BYTES = 2048
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_vendor, r_device;
    t_cmd cmd_f, cmd_b;
    logic q_full, q_empty, pop, push;
    logic [BAR_COUNT-1:0] bar_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vendor <= 16'd1;
            r_device <= 16'd2;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_VENDOR) r_vendor <= i_cfg_data;
            if (i_cfg_index == REG_DEVICE) r_device <= i_cfg_data;
        end
    end

    // Stall while the queue holds anything so decode sees settled BAR enables.
    assign o_stall = !q_empty;
    assign push = i_valid && !o_stall;

    pecb_front #(.ROM_BYTES(ROM_BYTES), .RAM_BYTES(RAM_BYTES)) u_front (
        .i_beat(i_data), .i_bar_en(bar_en), .o_cmd(cmd_f)
    );

    pecb_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cmd(cmd_f),
        .i_pop(pop), .o_full(q_full), .o_empty(q_empty), .o_cmd(cmd_b)
    );

    pecb_back #(.ROM_BYTES(ROM_BYTES), .RAM_BYTES(RAM_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vendor(r_vendor), .i_device(r_device),
        .i_cmd_valid(!q_empty), .i_cmd(cmd_b), .o_cmd_pop(pop), .o_bar_en(bar_en),
        .o_valid(o_valid), .i_stall(i_stall), .o_beat(o_data)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && push)) else $error("queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty) else $error("pop from empty queue");
    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.bytes_done <= 3'd4) else $error("bytes_done too large");
`endif

endmodule
